/* design/assert_macros.svh */
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CWT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CWT_ASSERT(lbl, prop, msg)
`define CWT_ASSERT_IMPL(lbl, ante, cons, msg)
`define CWT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/cwt_pkg.sv */
`default_nettype none
package cwt_pkg;

    localparam int SLOTS_DEFAULT = 256;

    localparam int OP_W   = 2;
    localparam int ID_W   = 32;
    localparam int ST_W   = 3;
    localparam int USED_W = 9;

    localparam logic [ID_W-1:0] EMPTY_MARK = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    localparam logic [ST_W-1:0] ST_PRESENT = 3'd0;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd1;
    localparam logic [ST_W-1:0] ST_STORED  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_ERASED  = 3'd4;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage
`default_nettype wire

/* design/cwt_ram.sv */
`default_nettype none
module cwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* design/cwt_ctrl.sv */
`default_nettype none
module cwt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output cwt_pkg::cmd_t      cmd,
    input  wire cwt_pkg::sts_t sts
);
    import cwt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FIN:
            begin
                // result register free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* design/cwt_dp.sv */
`default_nettype none
module cwt_dp #(
    parameter int SLOTS = cwt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cwt_pkg::cmd_t               cmd,
    output cwt_pkg::sts_t                    sts,
    input  wire logic [cwt_pkg::OP_W-1:0]    in_op,
    input  wire logic [cwt_pkg::ID_W-1:0]    in_id,
    output logic                             found,
    output logic      [cwt_pkg::ST_W-1:0]    status,
    output logic      [cwt_pkg::USED_W-1:0]  entries_used
);
    import cwt_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] FULL_AT = CW'(SLOTS - 2);

    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     idx_reg;
    logic              rd_v_reg;
    logic              hit_reg;
    logic              found_reg;
    logic [ST_W-1:0]   status_reg;
    logic [USED_W-1:0] used_reg;

    logic [ID_W-1:0]      rdata;
    logic                 match;
    logic                 skip;
    logic                 scan_go;
    logic                 we;
    logic                 found_new;
    logic [ST_W-1:0]      status_new;
    logic [CW+USED_W-1:0] cnt_ext;

    cwt_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (id_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // empty marker and erase need no scan
    assign skip    = (op_reg == OP_ERASE) || (id_reg == EMPTY_MARK);
    assign match   = rd_v_reg && (rdata == id_reg);
    assign scan_go = cmd.step && !skip && !hit_reg && (idx_reg < count_reg);

    assign sts.scan_done = !rd_v_reg && (skip || hit_reg || (idx_reg == count_reg));

    always_comb
    begin
        we         = 1'b0;
        count_next = count_reg;
        found_new  = 1'b0;
        status_new = ST_ERASED;
        if (op_reg == OP_ERASE)
        begin
            count_next = '0;
        end
        else if (op_reg != OP_STORE)
        begin
            found_new  = hit_reg;
            status_new = hit_reg ? ST_PRESENT : ST_ABSENT;
        end
        else if (hit_reg)
        begin
            found_new  = 1'b1;
            status_new = ST_PRESENT;
        end
        else if (count_reg >= FULL_AT)
        begin
            status_new = ST_FULL;
        end
        else
        begin
            status_new = ST_STORED;
            if (id_reg != EMPTY_MARK)
            begin
                we         = cmd.finish;
                count_next = count_reg + CW'(1);
            end
        end
    end

    assign cnt_ext = {{USED_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            rd_v_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg  <= '0;
                rd_v_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                rd_v_reg <= scan_go;
                hit_reg  <= hit_reg || match;
                if (scan_go)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op;
            id_reg <= in_id;
        end
        if (cmd.finish)
        begin
            found_reg  <= found_new;
            status_reg <= status_new;
            used_reg   <= cnt_ext[USED_W-1:0];
        end
    end

    assign found        = found_reg;
    assign status       = status_reg;
    assign entries_used = used_reg;

endmodule
`default_nettype wire

/* design/card_whitelist_table.sv */
// lookup or store presents its result after the table scan, the scan reading
// one entry per cycle from the card memory
// erase, the all-ones card and an empty table skip the scan
// one item at a time, next beat taken the cycle after the result is registered
// reset: asynchronous, clears fill count, handshake and scan state; no memory clearing pass
`default_nettype none
`include "assert_macros.svh"
module card_whitelist_table #(
    parameter int SLOTS = cwt_pkg::SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // card_id
    input  wire logic [1:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // entries_used, zero pad
    output logic      [3:0]  m_axis_tuser    // status, found
);
    import cwt_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic              found;
    logic [ST_W-1:0]   status;
    logic [USED_W-1:0] entries_used;

    cwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    cwt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_op        (s_axis_tuser),
        .in_id        (s_axis_tdata),
        .found        (found),
        .status       (status),
        .entries_used (entries_used)
    );

    assign m_axis_tdata = {{(16 - USED_W){1'b0}}, entries_used};
    assign m_axis_tuser = {status, found};

    `CWT_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.step, cmd.finish}), "overlapping commands")
    `CWT_ASSERT_NEXT(a_busy_after_load, cmd.load, !s_axis_tready, "ready while busy")
    `CWT_ASSERT_NEXT(a_result_valid, cmd.finish, m_axis_tvalid, "result not presented")
    `CWT_ASSERT_IMPL(a_status_range, m_axis_tvalid, m_axis_tuser[3:1] <= ST_ERASED,
        "status out of range")

endmodule
`default_nettype wire
